@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the hash insert unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OAHI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OAHI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/oahi_pkg.sv @@
// ----------------------------------------------------------------------------
// oahi_pkg
// Types, codes and constants of the open-addressing hash insert unit.
// ----------------------------------------------------------------------------
`default_nettype none

package oahi_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_W           = 31;
  localparam int SLOT_W          = 10;
  localparam int CNT_W           = 11;
  localparam int TOT_W           = 32;
  localparam int CFG_W           = 12;
  localparam int CFG_IDX_W       = 2;
  localparam int PRIME_W         = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PRIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT   = 2'd3;

  localparam logic [1:0] MODE_LINEAR    = 2'd0;
  localparam logic [1:0] MODE_QUADRATIC = 2'd1;
  localparam logic [1:0] MODE_DOUBLE    = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam logic [10:0] TABLE_SIZE_RST   = 11'd1021;
  localparam logic [1:0]  PROBE_MODE_RST   = 2'd1;
  localparam logic [11:0] SECOND_PRIME_RST = 12'd1031;
  localparam logic [10:0] LOAD_LIMIT_RST   = 11'd715;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 11'd2047;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  probe_collisions;
    logic [TOT_W-1:0]  total_collisions;
    logic [CNT_W-1:0]  element_count;
    logic              need_rehash;
    logic              table_full;
    logic [KEY_W-1:0]  read_key;
    logic              read_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    MOD_KEY_SIZE,
    MOD_KEY_PRIME,
    MOD_STEP_SIZE
  } mod_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH_GO,
    ST_HASH_WAIT,
    ST_PRIME_GO,
    ST_PRIME_WAIT,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_READ_RD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic     clr_write;
    logic     req_load;
    logic     mod_start;
    mod_sel_t mod_sel;
    logic     hash_latch;
    logic     prime_latch;
    logic     step_latch;
    logic     rd_slot;
    logic     ins_write;
    logic     probe_adv;
    logic     finish;
    logic     resp_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic req_is_read;
    logic mode_double;
    logic slot_free;
    logic probes_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ design/open_addressing_hash_insert_unit.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_insert_unit
// Open-addressing hash table with linear, quadratic or double-hash probing.
// ----------------------------------------------------------------------------
// Usage: each transaction on in_ is either an insert of a key or a read of
// one slot; each produces exactly one result transaction on out_. The unit
// works on one request at a time and holds in_stall high while busy.
// A read does a registered memory read of its slot, then loads the result.
// An insert first takes the key remainder (one bit per cycle in the shared
// remainder unit), in double-hashing mode then the key remainder by the
// second prime and the step size, then for each probe a registered memory
// read and a check, and then loads the result. After reset the unit
// sweeps the slot memory once, clearing one entry per cycle, and accepts
// no request until done; configuration writes are taken throughout. A
// finished result sits in the output register; while out_stall is high
// it holds, and the next request may already be accepted and worked on
// up to its result.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_insert_unit #(
  parameter int TABLE_DEPTH = oahi_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [oahi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [oahi_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire oahi_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output oahi_pkg::out_item_t                 out_data
);
  import oahi_pkg::*;

  cmd_t    cmd;
  status_t status;

  oahi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  oahi_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/oahi_mod_unit.sv @@
// ----------------------------------------------------------------------------
// oahi_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oahi_mod_unit #(
  parameter int DW = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [oahi_pkg::KEY_W-1:0] dividend,
  input  wire logic [DW-1:0]              divisor,
  output logic                            done,
  output logic [DW-1:0]                   rem
);
  import oahi_pkg::*;

  localparam int CW = $clog2(KEY_W + 1);

  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [KEY_W-1:0] dvd_r;
  logic [DW-1:0]    dvs_r;
  logic [DW:0]      trial;

  always_comb begin
    trial = {rem_r, dvd_r[KEY_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DW'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(KEY_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[KEY_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

@@ design/oahi_datapath.sv @@
// ----------------------------------------------------------------------------
// oahi_datapath
// Slot memory, probe index arithmetic, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oahi_datapath #(
  parameter int TABLE_DEPTH = oahi_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [oahi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [oahi_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire oahi_pkg::in_item_t             in_data,
  input  wire logic                           out_stall,
  input  wire oahi_pkg::cmd_t                 cmd,
  output oahi_pkg::status_t                   status,
  output logic                                out_valid,
  output oahi_pkg::out_item_t                 out_data
);
  import oahi_pkg::*;

  localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = (SW > PRIME_W) ? SW : PRIME_W;

  // Configuration registers.
  logic [10:0]        ts_r;
  logic [1:0]         pm_r;
  logic [11:0]        sp_r;
  logic [10:0]        ll_r;

  // Request and probe state.
  in_item_t           req_r;
  logic               slot_ok_r;
  logic [SW-1:0]      idx_r, idx_nxt;
  logic [SW-1:0]      d_r, d_nxt;
  logic [SW-1:0]      hits_r, hits_inc;
  logic [PRIME_W-1:0] kmodp_r;
  logic               found_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [AW-1:0]      clr_addr_r;
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  // Memory: the top bit of each word marks a stored key.
  logic [KEY_W:0]     mem [TABLE_DEPTH];
  logic [KEY_W:0]     rd_data_r;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [KEY_W:0]     wr_data;
  logic               mem_we;

  logic [31:0]        ts32, slot32, idx32, hits32;
  logic [SW-1:0]      size_c;
  logic [PRIME_W-1:0] p_c, step_c;
  logic [SW:0]        idx_sum, d_sum;
  logic [SW-1:0]      add_hits;
  logic [TOT_W:0]     tot_sum;
  logic [KEY_W-1:0]   mod_dvd;
  logic [DW-1:0]      mod_dvs;
  logic               mod_done;
  logic [DW-1:0]      mod_rem;
  logic               rd_valid;

  always_comb begin
    ts32 = 32'(ts_r);
    if (ts32 < 32'd2) begin
      size_c = SW'(2);
    end else if (ts32 > 32'(TABLE_DEPTH)) begin
      size_c = SW'(TABLE_DEPTH);
    end else begin
      size_c = SW'(ts_r);
    end
    p_c    = (sp_r == '0) ? PRIME_W'(1) : sp_r;
    step_c = p_c - kmodp_r;
  end

  always_comb begin
    case (cmd.mod_sel)
      MOD_KEY_SIZE: begin
        mod_dvd = req_r.key;
        mod_dvs = DW'(size_c);
      end
      MOD_KEY_PRIME: begin
        mod_dvd = req_r.key;
        mod_dvs = DW'(p_c);
      end
      MOD_STEP_SIZE: begin
        mod_dvd = KEY_W'(step_c);
        mod_dvs = DW'(size_c);
      end
      default: begin
        mod_dvd = req_r.key;
        mod_dvs = DW'(size_c);
      end
    endcase
  end

  oahi_mod_unit #(.DW(DW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_dvs),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Next probe position; both operands stay below the table size.
  always_comb begin
    hits_inc = hits_r + 1'b1;
    idx_sum  = {1'b0, idx_r} + {1'b0, d_r};
    idx_nxt  = (idx_sum >= {1'b0, size_c}) ? SW'(idx_sum - {1'b0, size_c}) : idx_sum[SW-1:0];
    d_sum    = {1'b0, d_r} + (SW + 1)'(2);
    d_nxt    = (d_sum >= {1'b0, size_c}) ? SW'(d_sum - {1'b0, size_c}) : d_sum[SW-1:0];
    add_hits = status.slot_free ? hits_r : hits_inc;
    tot_sum  = {1'b0, total_r} + (TOT_W + 1)'(add_hits);
    total_nxt = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
  end

  always_comb begin
    slot32  = 32'(req_r.slot);
    rd_addr = cmd.rd_slot ? slot32[AW-1:0] : idx_r[AW-1:0];
    mem_we  = cmd.clr_write | cmd.ins_write;
    wr_addr = cmd.clr_write ? clr_addr_r : idx_r[AW-1:0];
    wr_data = cmd.clr_write ? '0 : {1'b1, req_r.key};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    status.clr_last    = (clr_addr_r == AW'(TABLE_DEPTH - 1));
    status.mod_done    = mod_done;
    status.req_is_read = (req_r.req_type == REQ_READ);
    status.mode_double = (pm_r == MODE_DOUBLE);
    status.slot_free   = !rd_data_r[KEY_W];
    status.probes_done = (hits_inc == size_c);
    status.out_free    = !out_valid_r || !out_stall;
  end

  always_comb begin
    idx32    = 32'(idx_r);
    hits32   = 32'(hits_r);
    rd_valid = slot_ok_r && rd_data_r[KEY_W];
    out_nxt  = '0;
    out_nxt.total_collisions = total_r;
    out_nxt.element_count    = cnt_r;
    out_nxt.need_rehash      = (cnt_r >= ll_r);
    if (status.req_is_read) begin
      out_nxt.slot_index = req_r.slot;
      out_nxt.read_valid = rd_valid;
      out_nxt.read_key   = rd_valid ? rd_data_r[KEY_W-1:0] : '0;
    end else begin
      out_nxt.slot_index       = found_r ? idx32[SLOT_W-1:0] : '0;
      out_nxt.probe_collisions = hits32[CNT_W-1:0];
      out_nxt.table_full       = !found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r        <= TABLE_SIZE_RST;
      pm_r        <= PROBE_MODE_RST;
      sp_r        <= SECOND_PRIME_RST;
      ll_r        <= LOAD_LIMIT_RST;
      cnt_r       <= '0;
      total_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_SIZE:   ts_r <= cfg_wdata[10:0];
          CFG_PROBE_MODE:   pm_r <= cfg_wdata[1:0];
          CFG_SECOND_PRIME: sp_r <= cfg_wdata[11:0];
          CFG_LOAD_LIMIT:   ll_r <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (cmd.clr_write) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.finish) begin
        total_r <= total_nxt;
        if (status.slot_free && cnt_r < COUNT_MAX) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.resp_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r     <= in_data;
      slot_ok_r <= (32'(in_data.slot) < 32'(TABLE_DEPTH));
    end
    if (cmd.hash_latch) begin
      idx_r  <= SW'(mod_rem);
      hits_r <= '0;
      d_r    <= SW'(1);
    end
    if (cmd.prime_latch) begin
      kmodp_r <= PRIME_W'(mod_rem);
    end
    if (cmd.step_latch) begin
      d_r <= SW'(mod_rem);
    end
    if (cmd.probe_adv) begin
      hits_r <= hits_inc;
      idx_r  <= idx_nxt;
      if (pm_r == MODE_QUADRATIC) begin
        d_r <= d_nxt;
      end
    end
    if (cmd.finish) begin
      found_r <= status.slot_free;
    end
    if (cmd.resp_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ design/oahi_ctrl.sv @@
// ----------------------------------------------------------------------------
// oahi_ctrl
// Sequencer for the clearing pass, hashing, probing and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module oahi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req_type,
  output logic                   in_stall,
  input  wire oahi_pkg::status_t status,
  output oahi_pkg::cmd_t         cmd
);
  import oahi_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:      if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == REQ_READ) ? ST_READ_RD : ST_HASH_GO;
        end
      end
      ST_HASH_GO:    state_nxt = ST_HASH_WAIT;
      ST_HASH_WAIT: begin
        if (status.mod_done) begin
          state_nxt = status.mode_double ? ST_PRIME_GO : ST_PROBE_RD;
        end
      end
      ST_PRIME_GO:   state_nxt = ST_PRIME_WAIT;
      ST_PRIME_WAIT: if (status.mod_done) state_nxt = ST_STEP_GO;
      ST_STEP_GO:    state_nxt = ST_STEP_WAIT;
      ST_STEP_WAIT:  if (status.mod_done) state_nxt = ST_PROBE_RD;
      ST_PROBE_RD:   state_nxt = ST_PROBE_CHK;
      ST_PROBE_CHK: begin
        if (status.slot_free || status.probes_done) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_PROBE_RD;
        end
      end
      ST_READ_RD:    state_nxt = ST_RESP;
      ST_RESP:       if (status.out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mod_sel = MOD_KEY_SIZE;
    case (state_r)
      ST_CLEAR: cmd.clr_write = 1'b1;
      ST_IDLE:  cmd.req_load = accept;
      ST_HASH_GO: begin
        cmd.mod_start = 1'b1;
      end
      ST_HASH_WAIT: begin
        cmd.hash_latch = status.mod_done;
      end
      ST_PRIME_GO: begin
        cmd.mod_sel   = MOD_KEY_PRIME;
        cmd.mod_start = 1'b1;
      end
      ST_PRIME_WAIT: begin
        cmd.mod_sel     = MOD_KEY_PRIME;
        cmd.prime_latch = status.mod_done;
      end
      ST_STEP_GO: begin
        cmd.mod_sel   = MOD_STEP_SIZE;
        cmd.mod_start = 1'b1;
      end
      ST_STEP_WAIT: begin
        cmd.mod_sel    = MOD_STEP_SIZE;
        cmd.step_latch = status.mod_done;
      end
      ST_PROBE_RD: ;
      ST_PROBE_CHK: begin
        // A free slot ends the search; otherwise step on, and give up after
        // a full lap of probes.
        if (status.slot_free) begin
          cmd.ins_write = 1'b1;
          cmd.finish    = 1'b1;
        end else begin
          cmd.probe_adv = 1'b1;
          cmd.finish    = status.probes_done;
        end
      end
      ST_READ_RD: cmd.rd_slot = 1'b1;
      ST_RESP: begin
        cmd.rd_slot   = 1'b1;
        cmd.resp_load = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/oahi_checker.sv @@
// ----------------------------------------------------------------------------
// oahi_checker
// Port-level checks of the hash insert unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module oahi_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire oahi_pkg::out_item_t out_data
);
  import oahi_pkg::*;

  `OAHI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `OAHI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

  // A full table writes nothing, so the result names no slot and no key.
  `OAHI_ASSERT_SAME(a_full_result, clk, rst_n, out_valid && out_data.table_full, !out_data.read_valid && out_data.slot_index == '0 && out_data.read_key == '0)

  // A read transaction never reports insert-side probing.
  `OAHI_ASSERT_SAME(a_read_result, clk, rst_n, out_valid && out_data.read_valid, out_data.probe_collisions == '0 && !out_data.table_full)

endmodule

bind open_addressing_hash_insert_unit oahi_checker u_oahi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the open-addressing hash insert unit.
// Inserts and slot reads go in through the valid/stall request port. A
// behavioral copy of the table predicts every result, and each received
// transaction is compared with the oldest prediction. Directed cases cover
// out-of-range sizes, the unused probe mode, a zero second prime and a full
// table. Random traffic then runs under many register settings and three
// patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import oahi_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  // Shadow copy of the table and its registers.
  logic [10:0]      tbl_size;
  logic [1:0]       tbl_mode;
  logic [11:0]      tbl_prime;
  logic [10:0]      tbl_limit;
  logic [KEY_W-1:0] tbl_keys [DEPTH];
  bit               tbl_used [DEPTH];
  logic [CNT_W-1:0] tbl_count;
  logic [TOT_W-1:0] tbl_total;

  int               filled_slots[$];
  logic [KEY_W-1:0] inserted_keys[$];
  out_item_t        pending_results[$];
  int               mismatches = 0;
  int               send_gap_pct = 8;
  int               out_stall_pct = 71;

  open_addressing_hash_insert_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic out_item_t predict_hash_result(in_item_t req);
    out_item_t       res;
    int unsigned     size;
    int unsigned     idx;
    int unsigned     hits;
    longint unsigned key;
    longint unsigned step;
    longint unsigned offset;
    longint unsigned sum;
    bit              found;
    res = '0;
    key = req.key;
    size = tbl_size;
    if (size < 2) size = 2;
    if (size > DEPTH) size = DEPTH;
    if (req.req_type == REQ_INSERT) begin
      hits = 0;
      idx = 0;
      found = 1'b0;
      for (int unsigned i = 0; i < size; i++) begin
        case (tbl_mode)
          MODE_QUADRATIC: offset = longint'(i) * i;
          MODE_DOUBLE: begin
            step = (tbl_prime == 0) ? 1 : tbl_prime;
            offset = longint'(i) * (step - key % step);
          end
          default: offset = i;
        endcase
        idx = 32'((key + offset) % size);
        if (!tbl_used[idx]) begin
          found = 1'b1;
          break;
        end
        hits++;
      end
      if (found) begin
        tbl_keys[idx] = req.key;
        tbl_used[idx] = 1'b1;
        filled_slots.push_back(idx);
        if (tbl_count != COUNT_MAX) tbl_count++;
        res.slot_index = SLOT_W'(idx);
      end else begin
        res.table_full = 1'b1;
      end
      sum = longint'(tbl_total) + hits;
      tbl_total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      res.probe_collisions = CNT_W'(hits);
    end else begin
      res.slot_index = req.slot;
      if (tbl_used[req.slot]) begin
        res.read_key = tbl_keys[req.slot];
        res.read_valid = 1'b1;
      end
    end
    res.total_collisions = tbl_total;
    res.element_count = tbl_count;
    res.need_rehash = (tbl_count >= tbl_limit);
    return res;
  endfunction

  // Receiver side: random stall, driven at the rising edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Outputs are sampled at the falling edge, where they are stable until the
  // edge that completes the transaction.
  always @(negedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("result differs: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  // Sends one request; the valid stays high after acceptance so that a
  // back-to-back request needs no second assignment in the same step.
  task automatic send_request(input in_item_t req);
    int gap;
    bit taken;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    pending_results.push_back(predict_hash_result(req));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Registers change only once every transaction in flight has finished.
  task automatic set_config(input logic [10:0] size, input logic [1:0] mode,
                            input logic [11:0] prime, input logic [10:0] limit);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TABLE_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_index <= CFG_PROBE_MODE;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_index <= CFG_SECOND_PRIME;
    cfg_wdata <= prime;
    @(posedge clk);
    cfg_index <= CFG_LOAD_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_size = size;
    tbl_mode = mode;
    tbl_prime = prime;
    tbl_limit = limit;
  endtask

  task automatic insert_key(input logic [KEY_W-1:0] key);
    in_item_t req;
    req.req_type = REQ_INSERT;
    req.key = key;
    req.slot = $urandom;
    inserted_keys.push_back(key);
    send_request(req);
  endtask

  task automatic read_slot(input logic [SLOT_W-1:0] slot);
    in_item_t req;
    req.req_type = REQ_READ;
    req.key = $urandom;
    req.slot = slot;
    send_request(req);
  endtask

  // Reset settings: quadratic probing over 1021 slots.
  task automatic test_reset_settings();
    insert_key('0);
    insert_key({KEY_W{1'b1}});
    insert_key(31'd1021);
    insert_key(31'd2042);
    read_slot(10'd0);
    read_slot(10'd1);
    wait_idle();
  endtask

  // Sizes below two, the unused mode and a zero prime; the two live slots
  // are already taken, so these inserts find the table full.
  task automatic test_small_and_full();
    set_config(11'd0, 2'd3, 12'd0, 11'd0);
    insert_key(31'd5);
    insert_key(31'd8);
    set_config(11'd1, MODE_DOUBLE, 12'd0, 11'd2047);
    insert_key(31'd9);
    read_slot(10'd0);
    wait_idle();
  endtask

  // Sizes at and beyond the storage, double hashing with extreme primes, then a small linear table.
  task automatic test_large_sizes();
    set_config(11'd2047, MODE_DOUBLE, 12'd0, 11'd2047);
    insert_key(31'd1023);
    insert_key(31'd2047);
    read_slot(10'd1023);
    set_config(11'd1024, MODE_DOUBLE, 12'd4095, 11'd3);
    insert_key(31'h7FFF_FC00);
    insert_key(31'h7FFF_FC00);
    insert_key(31'd4095);
    set_config(11'd5, MODE_LINEAR, 12'd7, 11'd4);
    insert_key(31'd3);
    insert_key(31'd3);
    read_slot(10'd4);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n_blocks, input int per_block);
    logic [10:0] size;
    logic [11:0] prime;
    logic [10:0] limit;
    int          pick;
    for (int b = 0; b < n_blocks; b++) begin
      pick = $urandom_range(9);
      if (pick <= 5) size = $urandom_range(2, 67);
      else if (pick == 6) size = $urandom_range(0, 1);
      else if (pick == 7) size = $urandom_range(1024, 2047);
      else if (pick == 8) size = $urandom_range(68, 1023);
      else size = 11'd1021;
      prime = ($urandom_range(3) == 0) ? $urandom_range(0, 13) : $urandom_range(0, 4095);
      limit = ($urandom_range(1) == 0) ? $urandom_range(0, 2047)
                                       : tbl_count + $urandom_range(0, 8);
      set_config(size, $urandom_range(0, 3), prime, limit);
      for (int k = 0; k < per_block; k++) begin
        pick = $urandom_range(99);
        if (pick < 22 && filled_slots.size() != 0) begin
          read_slot(filled_slots[$urandom_range(0, filled_slots.size() - 1)]);
        end else if (pick < 40) begin
          insert_key($urandom_range(0, 4095));
        end else if (pick < 52 && inserted_keys.size() != 0) begin
          insert_key(inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
        end else begin
          insert_key($urandom);
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    tbl_size = TABLE_SIZE_RST;
    tbl_mode = PROBE_MODE_RST;
    tbl_prime = SECOND_PRIME_RST;
    tbl_limit = LOAD_LIMIT_RST;
    tbl_count = '0;
    tbl_total = '0;
    for (int s = 0; s < DEPTH; s++) begin
      tbl_keys[s] = '0;
      tbl_used[s] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_small_and_full();
    test_large_sizes();

    test_random_traffic(10, 40);
    send_gap_pct = 71;
    out_stall_pct = 8;
    test_random_traffic(10, 40);
    send_gap_pct = 0;
    out_stall_pct = 0;
    test_random_traffic(10, 40);

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("open_addressing_hash_insert_unit: match");
    end else begin
      $display("open_addressing_hash_insert_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("open_addressing_hash_insert_unit: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/oahi_pkg.sv
design/oahi_mod_unit.sv
design/oahi_datapath.sv
design/oahi_ctrl.sv
design/open_addressing_hash_insert_unit.sv
design/oahi_checker.sv
tb/tb_top.sv
